### sv/bps_pkg.sv
// Package for the Bayer plane statistics core: shared types and constants.
// No dependencies; compiled first.
package bps_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK1  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK2  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK3  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CEILING = 3'd5;

    localparam logic [15:0] WHITE_RESET   = 16'hFFFF;
    localparam logic [16:0] CEILING_RESET = 17'd62259;
    localparam logic [16:0] FRACTION_ONE  = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MEAN_PREP,
        ST_MEAN_DIV,
        ST_VAR_MUL,
        ST_VAR_DIV,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        row_end;
        logic        frame_end;
    } pix_item_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [25:0] sample_count;
        logic [20:0] mean_q4;
        logic [19:0] stddev_q4;
        logic [16:0] min_value;
        logic [16:0] max_value;
        logic [25:0] below_black_count;
        logic [25:0] saturated_count;
        logic [25:0] ceiling_count;
        logic        ceiling_armed;
        logic        overflow;
        logic        last;
    } stat_item_t;

endpackage

### sv/bps_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing; payload type supplied by parameter.
interface bps_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/bayer_plane_statistics_core.sv
// Bayer plane statistics core: per-position accumulators, mean and stddev.
// Depends on bps_pkg and bps_stream_if.
//
// Usage: pixels arrive on pix_in (raster order, row_end/frame_end marks);
// four statistics items leave on stat_out, channels 0..3, last on channel 3.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data while
// the block is idle; indexes beyond 5 are ignored.
// Sequence: an ordinary pixel is accepted, then one read-modify-write of its
// position's accumulators goes through the shared update datapath; no new
// pixel is taken until that update is done. A frame_end pixel takes its update
// and then, per position, a set-up step, a 64-step restoring mean division,
// six 32x32 partial products for the variance numerator, a 128-bit restoring
// division one bit per cycle, a 32-step integer square root and the result
// hand-off. Input is held off throughout. The result register holds an item
// until stat_out.ready; a stall simply extends the frame-end sequence.
// Reset: all accumulators, parities and flags clear; black levels 0, white
// 65535, ceiling fraction 62259. Accumulators and flags also clear after the
// fourth result of a frame; the parities clear with the frame_end update.
module bayer_plane_statistics_core #(
    parameter int COUNT_BITS = 26,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bps_stream_if.sink                   pix_in,
    bps_stream_if.source                 stat_out,
    input  logic                         cfg_we,
    input  logic [bps_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [bps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import bps_pkg::*;

    localparam int SUM_BITS = COUNT_BITS + 17;
    localparam int SQ_BITS  = COUNT_BITS + 32;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [15:0] black_reg [4];
    logic [15:0] white_reg;
    logic [16:0] frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) black_reg[i] <= '0;
            white_reg <= WHITE_RESET;
            frac_reg  <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_BLACK0, REG_BLACK1, REG_BLACK2, REG_BLACK3:
                    black_reg[cfg_idx[1:0]] <= cfg_data[15:0];
                REG_WHITE:   white_reg <= cfg_data[15:0];
                REG_CEILING: frac_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // accumulators, one row per position
    logic [COUNT_BITS-1:0] count_reg [4];
    logic [SUM_BITS-1:0]   sum_reg   [4];
    logic [SQ_BITS-1:0]    sumsq_reg [4];
    logic [16:0]           min_reg   [4];
    logic [16:0]           max_reg   [4];
    logic [COUNT_BITS-1:0] below_reg [4];
    logic [COUNT_BITS-1:0] sat_reg   [4];
    logic [COUNT_BITS-1:0] ceil_reg  [4];
    logic [3:0]            seen_reg, ovf_reg;
    logic                  rowp_reg, colp_reg;

    state_t state_reg, state_next;
    pix_item_t item_reg;
    logic [1:0] ch_reg;          // position being reported
    logic [7:0] step_reg;        // iteration counter

    // shared iterative datapath registers
    logic [63:0]  num_hi_reg, num_lo_reg, den_reg, rem_reg, quo_reg;
    logic [63:0]  mag_reg;
    logic [2:0]   mstep_reg;
    logic [63:0]  pa_hi_reg, pa_lo_reg;  // n*sumsq product
    logic [20:0]  mean_reg;
    logic [63:0]  sq_x_reg, sq_res_reg, sq_b_reg;
    stat_item_t   out_reg;
    logic         out_valid_reg;

    // ---------------- pixel update datapath ----------------
    logic [1:0]  pos;
    logic [PIXEL_BITS-1:0] raw;
    logic signed [17:0] v;
    logic signed [35:0] vsq;
    logic        thr_ok;
    logic signed [34:0] vscaled;
    logic [33:0] thr_prod;
    logic        full;

    function automatic logic thr_valid_f(input logic [16:0] f, input logic [15:0] w,
                                         input logic [15:0] b);
        thr_valid_f = (f != '0) && (f <= FRACTION_ONE) && (w > b);
    endfunction

    assign pos   = {rowp_reg, colp_reg};
    assign raw   = item_reg.pixel[PIXEL_BITS-1:0];
    assign v     = $signed({2'b00, 16'(raw)}) - $signed({2'b00, black_reg[pos]});
    assign vsq   = v * v;
    assign thr_ok = thr_valid_f(frac_reg, white_reg, black_reg[pos]);
    assign vscaled = {v[16:0], 16'h0000} ;
    assign thr_prod = frac_reg * (17'(white_reg) - 17'(black_reg[pos]));
    assign full  = (count_reg[pos] >= CMAX);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (pix_in.valid) state_next = ST_UPDATE;
            ST_UPDATE:    state_next = item_reg.frame_end ? ST_MEAN_PREP : ST_IDLE;
            ST_MEAN_PREP: state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:  if (step_reg == 8'd63) state_next = ST_VAR_MUL;
            ST_VAR_MUL:   if (mstep_reg == 3'd5 && step_reg == 8'd1) state_next = ST_VAR_DIV;
            ST_VAR_DIV:   if (step_reg == 8'd127) state_next = ST_SQRT;
            ST_SQRT:      if (step_reg == 8'd31) state_next = ST_EMIT;
            ST_EMIT:      if (!out_valid_reg)
                              state_next = (ch_reg == 2'd3) ? ST_IDLE : ST_MEAN_PREP;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pix_in.ready   = (state_reg == ST_IDLE);
        stat_out.valid = out_valid_reg;
        stat_out.data  = out_reg;
    end

    // helper values for the current reporting position
    logic [COUNT_BITS-1:0] n_cur;
    logic [SUM_BITS-1:0]   s_cur;
    logic [63:0]           s_mag;
    logic [63:0]           sq_cur;
    assign n_cur  = count_reg[ch_reg];
    assign s_cur  = sum_reg[ch_reg];
    assign s_mag  = s_cur[SUM_BITS-1] ? 64'(-$signed(s_cur)) : 64'(s_cur);
    assign sq_cur = 64'(sumsq_reg[ch_reg]);

    // 32x32 partial multiplier shared by the variance steps
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [63:0] div_r_sh;
    logic        div_bit, div_carry, div_ge;
    logic [63:0] sq_t;
    logic [63:0] n64;
    assign n64 = 64'(n_cur);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (mstep_reg)
            3'd0: begin mul_a = n64[31:0];      mul_b = sq_cur[31:0];   end
            3'd1: begin mul_a = n64[31:0];      mul_b = sq_cur[63:32];  end
            3'd2: begin mul_a = mag_reg[31:0];  mul_b = mag_reg[31:0];  end
            3'd3: begin mul_a = mag_reg[31:0];  mul_b = mag_reg[63:32]; end
            3'd4: begin mul_a = mag_reg[63:32]; mul_b = mag_reg[63:32]; end
            default: begin mul_a = n64[31:0]; mul_b = n64[31:0]; end
        endcase
        div_bit   = num_hi_reg[63];
        div_carry = rem_reg[63];
        div_r_sh  = {rem_reg[62:0], div_bit};
        div_ge    = div_carry || (div_r_sh >= den_reg);
        sq_t      = sq_res_reg + sq_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rowp_reg      <= 1'b0;
            colp_reg      <= 1'b0;
            seen_reg      <= '0;
            ovf_reg       <= '0;
            ch_reg        <= '0;
            step_reg      <= '0;
            mstep_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                count_reg[i] <= '0; sum_reg[i] <= '0; sumsq_reg[i] <= '0;
                min_reg[i] <= '0; max_reg[i] <= '0;
                below_reg[i] <= '0; sat_reg[i] <= '0; ceil_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && stat_out.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (pix_in.valid) item_reg <= pix_in.data;
                ST_UPDATE:
                begin
                    if (full) ovf_reg[pos] <= 1'b1;
                    else
                    begin
                        count_reg[pos] <= count_reg[pos] + 1'b1;
                        sum_reg[pos]   <= sum_reg[pos] + SUM_BITS'(v);
                        sumsq_reg[pos] <= sumsq_reg[pos] + SQ_BITS'(vsq);
                    end
                    if (!seen_reg[pos] || $signed(v[16:0]) < $signed(min_reg[pos]))
                        min_reg[pos] <= v[16:0];
                    if (!seen_reg[pos] || $signed(v[16:0]) > $signed(max_reg[pos]))
                        max_reg[pos] <= v[16:0];
                    seen_reg[pos] <= 1'b1;
                    if (v[17])
                    begin
                        if (below_reg[pos] >= CMAX) ovf_reg[pos] <= 1'b1;
                        else below_reg[pos] <= below_reg[pos] + 1'b1;
                    end
                    if (16'(raw) >= white_reg)
                    begin
                        if (sat_reg[pos] >= CMAX) ovf_reg[pos] <= 1'b1;
                        else sat_reg[pos] <= sat_reg[pos] + 1'b1;
                    end
                    if (thr_ok && !v[17] && 35'(vscaled) >= 35'(thr_prod))
                    begin
                        if (ceil_reg[pos] >= CMAX) ovf_reg[pos] <= 1'b1;
                        else ceil_reg[pos] <= ceil_reg[pos] + 1'b1;
                    end
                    if (item_reg.row_end)
                    begin
                        colp_reg <= 1'b0;
                        rowp_reg <= ~rowp_reg;
                    end
                    else colp_reg <= ~colp_reg;
                    if (item_reg.frame_end)
                    begin
                        rowp_reg <= 1'b0;
                        colp_reg <= 1'b0;
                        ch_reg   <= '0;
                    end
                end
                ST_MEAN_PREP:
                begin
                    // mean = (32*|s| + n) / 2n, restoring division, 64 steps
                    num_hi_reg <= (s_mag << 5) + n64;
                    den_reg    <= n64 << 1;
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    mag_reg    <= s_mag;
                    step_reg   <= '0;
                    mstep_reg  <= '0;
                end
                ST_MEAN_DIV:
                begin
                    num_hi_reg <= num_hi_reg << 1;
                    rem_reg    <= div_ge ? div_r_sh - den_reg : div_r_sh;
                    quo_reg    <= {quo_reg[62:0], div_ge};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == 8'd63)
                    begin
                        mean_reg <= s_cur[SUM_BITS-1] ?
                                    21'(-{quo_reg[62:0], div_ge}) : 21'({quo_reg[62:0], div_ge});
                        step_reg <= '0;
                    end
                end
                ST_VAR_MUL:
                begin
                    // products in order: n*sumsq lo/hi, |s|^2 in three parts, n*n
                    if (step_reg == 8'd0) step_reg <= 8'd1;
                    else
                    begin
                        step_reg  <= '0;
                        mstep_reg <= mstep_reg + 1'b1;
                        unique case (mstep_reg)
                            3'd0: begin pa_lo_reg <= mul_p; pa_hi_reg <= '0; end
                            3'd1:
                                {pa_hi_reg, pa_lo_reg} <=
                                    {pa_hi_reg, pa_lo_reg} + ({64'd0, mul_p} << 32);
                            3'd2: {num_hi_reg, num_lo_reg} <= {64'd0, mul_p};
                            3'd3:
                                {num_hi_reg, num_lo_reg} <=
                                    {num_hi_reg, num_lo_reg} + ({64'd0, mul_p} << 33);
                            3'd4:
                                {num_hi_reg, num_lo_reg} <=
                                    {num_hi_reg, num_lo_reg} + ({64'd0, mul_p} << 64);
                            default:
                            begin
                                // n*sumsq - |s|^2, clamped at zero, scaled by 256
                                if ({pa_hi_reg, pa_lo_reg} < {num_hi_reg, num_lo_reg} ||
                                    n_cur == '0)
                                    {num_hi_reg, num_lo_reg} <= '0;
                                else
                                    {num_hi_reg, num_lo_reg} <=
                                        ({pa_hi_reg, pa_lo_reg} - {num_hi_reg, num_lo_reg}) << 8;
                                den_reg <= (n_cur == '0) ? 64'd1 : mul_p;
                                rem_reg <= '0;
                                quo_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_VAR_DIV:
                begin
                    {num_hi_reg, num_lo_reg} <= {num_hi_reg, num_lo_reg} << 1;
                    rem_reg  <= div_ge ? div_r_sh - den_reg : div_r_sh;
                    quo_reg  <= {quo_reg[62:0], div_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 8'd127)
                    begin
                        sq_x_reg   <= {quo_reg[62:0], div_ge};
                        sq_res_reg <= '0;
                        sq_b_reg   <= 64'd1 << 62;
                        step_reg   <= '0;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_x_reg >= sq_t)
                    begin
                        sq_x_reg   <= sq_x_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_b_reg;
                    end
                    else sq_res_reg <= sq_res_reg >> 1;
                    sq_b_reg <= sq_b_reg >> 2;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 8'd31) step_reg <= '0;
                end
                ST_EMIT:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_reg.channel           <= ch_reg;
                        out_reg.sample_count      <= 26'(n_cur);
                        out_reg.mean_q4           <= (n_cur == '0) ? '0 : mean_reg;
                        out_reg.stddev_q4         <= (n_cur == '0) ? '0 :
                            (sq_res_reg > 64'hFFFFF) ? 20'hFFFFF : sq_res_reg[19:0];
                        out_reg.min_value         <= (n_cur == '0) ? '0 : min_reg[ch_reg];
                        out_reg.max_value         <= (n_cur == '0) ? '0 : max_reg[ch_reg];
                        out_reg.below_black_count <= 26'(below_reg[ch_reg]);
                        out_reg.saturated_count   <= 26'(sat_reg[ch_reg]);
                        out_reg.ceiling_count     <= 26'(ceil_reg[ch_reg]);
                        out_reg.ceiling_armed     <=
                            thr_valid_f(frac_reg, white_reg, black_reg[ch_reg]);
                        out_reg.overflow          <= ovf_reg[ch_reg];
                        out_reg.last              <= (ch_reg == 2'd3);
                        ch_reg                    <= ch_reg + 1'b1;
                        if (ch_reg == 2'd3)
                        begin
                            seen_reg <= '0;
                            ovf_reg  <= '0;
                            for (int i = 0; i < 4; i++)
                            begin
                                count_reg[i] <= '0; sum_reg[i] <= '0; sumsq_reg[i] <= '0;
                                min_reg[i] <= '0; max_reg[i] <= '0;
                                below_reg[i] <= '0; sat_reg[i] <= '0; ceil_reg[i] <= '0;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // Input is only taken while the sequencer is idle.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |-> state_reg == ST_IDLE)
        else $error("pixel accepted while busy");
    // A result is raised only from the hand-off step.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside hand-off");
    // The last flag travels with channel three only.
    a_last_ch3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == (out_reg.channel == 2'd3)))
        else $error("last flag on wrong channel");
`endif
endmodule

### dv/bayer_plane_statistics_core_test.sv
// Testbench for bayer_plane_statistics_core: drives pixel frames and register settings,
// and predicts every statistics item with its own model in a small scoreboard class.
// Depends on bps_pkg, bps_stream_if and the core itself.
module bayer_plane_statistics_core_test;
    import bps_pkg::*;

    localparam int COUNT_W     = 26;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 500;

    // indexes past the register list, written to check that they are ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // Scoreboard: mirrors the registers and accumulators and holds the
    // statistics items still to come, oldest first.
    class plane_stats_scoreboard;
        bit [15:0]    black[4];
        bit [15:0]    white;
        bit [16:0]    fraction;
        bit           row_par, col_par;
        bit [63:0]    n_acc[4];
        longint       sum_acc[4];
        bit [63:0]    sq_acc[4];
        longint       lo_acc[4], hi_acc[4];
        bit [63:0]    below_acc[4], sat_acc[4], ceil_acc[4];
        bit           seen[4], ovf[4];
        stat_item_t   expected_stats[$];
        int           failures;
        int           results_seen;

        function new();
            for (int p = 0; p < 4; p++) black[p] = '0;
            white    = WHITE_RESET;
            fraction = CEILING_RESET;
            failures = 0;
            results_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            for (int p = 0; p < 4; p++)
            begin
                n_acc[p] = 0; sum_acc[p] = 0; sq_acc[p] = 0;
                lo_acc[p] = 0; hi_acc[p] = 0;
                below_acc[p] = 0; sat_acc[p] = 0; ceil_acc[p] = 0;
                seen[p] = 0; ovf[p] = 0;
            end
            row_par = 0;
            col_par = 0;
        endfunction

        function void set_reg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_BLACK0, REG_BLACK1, REG_BLACK2, REG_BLACK3: black[idx[1:0]] = val[15:0];
                REG_WHITE:   white = val[15:0];
                REG_CEILING: fraction = val;
                default: ;
            endcase
        endfunction

        function bit thr_ok(int p);
            return fraction != 0 && fraction <= FRACTION_ONE && white > black[p];
        endfunction

        function void bump(ref bit [63:0] c, input int p);
            if (c >= (64'd1 << COUNT_W) - 1) ovf[p] = 1;
            else c++;
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] x);
            bit [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end
                else res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function bit [20:0] mean_of(int p);
            bit [63:0] mag, q;
            if (n_acc[p] == 0) return '0;
            mag = sum_acc[p] < 0 ? -sum_acc[p] : sum_acc[p];
            q = (mag * 32 + n_acc[p]) / (2 * n_acc[p]);
            if (sum_acc[p] < 0) q = -q;
            return q[20:0];
        endfunction

        function bit [19:0] stddev_of(int p);
            bit [127:0] a, b, m, d;
            bit [63:0]  mag, q;
            if (n_acc[p] == 0) return '0;
            mag = sum_acc[p] < 0 ? -sum_acc[p] : sum_acc[p];
            a = {64'd0, n_acc[p]} * {64'd0, sq_acc[p]};
            b = {64'd0, mag} * {64'd0, mag};
            if (a < b) return '0;
            m = (a - b) << 8;
            d = {64'd0, n_acc[p] * n_acc[p]};
            q = int_sqrt(64'(m / d));
            return q > 64'hFFFFF ? 20'hFFFFF : q[19:0];
        endfunction

        // Advance the model by one accepted pixel; queue four items on frame end.
        function void note_pixel(pix_item_t it);
            int         p;
            longint     v;
            stat_item_t s;
            p = {row_par, col_par};
            v = longint'(it.pixel) - longint'(black[p]);
            if (n_acc[p] >= (64'd1 << COUNT_W) - 1) ovf[p] = 1;
            else
            begin
                n_acc[p]++;
                sum_acc[p] += v;
                sq_acc[p] += 64'(v * v);
            end
            if (!seen[p])
            begin
                lo_acc[p] = v; hi_acc[p] = v; seen[p] = 1;
            end
            else
            begin
                if (v < lo_acc[p]) lo_acc[p] = v;
                if (v > hi_acc[p]) hi_acc[p] = v;
            end
            if (v < 0) bump(below_acc[p], p);
            if (it.pixel >= white) bump(sat_acc[p], p);
            if (thr_ok(p) && v * 65536 >= longint'(fraction) * longint'(white - black[p]))
                bump(ceil_acc[p], p);
            if (it.row_end)
            begin
                col_par = 0;
                row_par ^= 1;
            end
            else col_par ^= 1;
            if (!it.frame_end) return;
            for (int k = 0; k < 4; k++)
            begin
                s.channel           = 2'(k);
                s.sample_count      = n_acc[k][25:0];
                s.mean_q4           = mean_of(k);
                s.stddev_q4         = stddev_of(k);
                s.min_value         = n_acc[k] != 0 ? 17'(lo_acc[k]) : '0;
                s.max_value         = n_acc[k] != 0 ? 17'(hi_acc[k]) : '0;
                s.below_black_count = below_acc[k][25:0];
                s.saturated_count   = sat_acc[k][25:0];
                s.ceiling_count     = ceil_acc[k][25:0];
                s.ceiling_armed     = thr_ok(k);
                s.overflow          = ovf[k];
                s.last              = (k == 3);
                expected_stats.push_back(s);
            end
            clear_frame();
        endfunction

        function void cmp(string name, bit [63:0] e, bit [63:0] a, ref bit bad);
            if (e != a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                bad = 1;
            end
        endfunction

        function void check_stat(stat_item_t a);
            stat_item_t e;
            bit         bad;
            bad = 0;
            results_seen++;
            if (expected_stats.size() == 0)
            begin
                $error("statistics item with nothing expected");
                failures++;
                return;
            end
            e = expected_stats.pop_front();
            cmp("channel", e.channel, a.channel, bad);
            cmp("sample_count", e.sample_count, a.sample_count, bad);
            cmp("mean_q4", e.mean_q4, a.mean_q4, bad);
            cmp("stddev_q4", e.stddev_q4, a.stddev_q4, bad);
            cmp("min_value", e.min_value, a.min_value, bad);
            cmp("max_value", e.max_value, a.max_value, bad);
            cmp("below_black_count", e.below_black_count, a.below_black_count, bad);
            cmp("saturated_count", e.saturated_count, a.saturated_count, bad);
            cmp("ceiling_count", e.ceiling_count, a.ceiling_count, bad);
            cmp("ceiling_armed", e.ceiling_armed, a.ceiling_armed, bad);
            cmp("overflow", e.overflow, a.overflow, bad);
            cmp("last", e.last, a.last, bad);
            if (bad) failures++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    bps_stream_if #(.payload_t(pix_item_t))  pix_ch();
    bps_stream_if #(.payload_t(stat_item_t)) stat_ch();

    bayer_plane_statistics_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_ch.sink),
        .stat_out (stat_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    plane_stats_scoreboard sb = new();

    bit quiet;         // hold both sides free of random idling
    bit held_off;      // the long receiver hold-off has happened
    int pixels_sent;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off while pixels keep coming.
    initial
    begin
        stat_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && sb.results_seen >= 40)
            begin
                held_off = 1;
                stat_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stat_ch.ready <= quiet || $urandom_range(0, 99) >= 14;
        end
    end

    // Check each accepted statistics item.
    always @(posedge clk)
        if (rst_n && stat_ch.valid && stat_ch.ready)
            sb.check_stat(stat_ch.data);

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (stat_ch.valid && stat_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Write one register; the caller lowers the enable after the last write.
    task automatic write_reg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_DATA_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(bit [15:0] b0, bit [15:0] b1, bit [15:0] b2, bit [15:0] b3,
                             bit [15:0] wl, bit [16:0] fr);
        write_reg(REG_BLACK0, 17'(b0));
        write_reg(REG_BLACK1, 17'(b1));
        write_reg(REG_BLACK2, 17'(b2));
        write_reg(REG_BLACK3, 17'(b3));
        write_reg(REG_WHITE, 17'(wl));
        write_reg(REG_CEILING, fr);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel item and hold it until accepted; note it on acceptance.
    task automatic send_pixel(bit [15:0] px, bit re, bit fe);
        pix_item_t it;
        it.pixel     = px;
        it.row_end   = re;
        it.frame_end = fe;
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        sb.note_pixel(it);
        pixels_sent++;
    endtask

    // Wait until every expected item has arrived, then let the core settle.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_stats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Pick a pixel near the interesting levels of the current setting.
    function automatic bit [15:0] pick_pixel(int p);
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return sb.black[p] + 16'($urandom_range(0, 4)) - 16'd2;
            3: return sb.white - 16'($urandom_range(0, 3));
            default: return 16'($urandom());
        endcase
    endfunction

    // One well-formed frame with random geometry and content.
    task automatic send_frame();
        int rows, cols;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            cols = $urandom_range(1, 6);
            for (int c = 0; c < cols; c++)
                send_pixel(pick_pixel({r[0], c[0]}), c == cols - 1,
                           r == rows - 1 && c == cols - 1);
        end
    endtask

    initial
    begin
        // Drive every input to a known value from time zero.
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        quiet = 0;
        pixels_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers; single-pixel frame leaves three positions empty.
        send_pixel(16'hFFFF, 1'b0, 1'b1);
        // Full 2x2 frame at the extremes and around the ceiling: parity walks through all positions.
        send_pixel(16'h0000, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 1'b1, 1'b0);
        send_pixel(16'hF333, 1'b0, 1'b0);
        send_pixel(16'hF332, 1'b1, 1'b1);
        // Row end on every pixel keeps the column parity at zero.
        send_pixel(16'h1234, 1'b1, 1'b0);
        send_pixel(16'h5678, 1'b1, 1'b0);
        send_pixel(16'h9ABC, 1'b1, 1'b1);
        drain();

        // Black at the top, white at zero, threshold disabled: all below black.
        write_all(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000, 17'd0);
        send_pixel(16'h0000, 1'b0, 1'b0);
        send_pixel(16'hFFFE, 1'b1, 1'b0);
        send_pixel(16'h7FFF, 1'b0, 1'b0);
        send_pixel(16'h0000, 1'b1, 1'b1);
        drain();

        // Full-scale fraction, then a fraction out of range, and ignored indexes.
        write_all(16'd64, 16'd64, 16'd64, 16'd64, 16'd1000, FRACTION_ONE);
        send_pixel(16'd1000, 1'b0, 1'b0);
        send_pixel(16'd999, 1'b1, 1'b0);
        send_pixel(16'd63, 1'b0, 1'b0);
        send_pixel(16'd1064, 1'b1, 1'b1);
        drain();
        write_reg(REG_SPARE_LO, 17'h1FFFF);
        write_reg(REG_SPARE_HI, 17'h1FFFF);
        write_reg(REG_CEILING, 17'h1FFFF);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_pixel(16'hFFFF, 1'b0, 1'b0);
        send_pixel(16'h0040, 1'b1, 1'b1);
        drain();

        // Random phases: several settings, one of them with no idling at all.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 17'd1);
                1: write_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, FRACTION_ONE);
                default: write_all(16'($urandom_range(0, 4095)), 16'($urandom()),
                                   16'($urandom_range(0, 4095)), 16'($urandom_range(0, 512)),
                                   16'($urandom()), 17'($urandom()));
            endcase
            quiet = (ph == 4);
            while (pixels_sent < 20 + (ph + 1) * 27)
                send_frame();
            drain();
        end
        quiet = 0;

        if (sb.failures == 0 && sb.expected_stats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
